### src/gsd_pkg.sv
// Shared types, register indexes and constants for the GNSS spoofing detector.
package gsd_pkg;

  localparam int unsigned LIMIT_W   = 17;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned VAL_W     = 16;
  localparam int unsigned NUM_DIFFS = 5;
  localparam int unsigned IN_DATA_W  = 192;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;

  // An all-zero receiver sample never reports spoofing when this is set.
  localparam logic REQUIRE_RX_DATA = 1'b1;

  typedef enum logic [2:0] {
    REG_SPEED_LIMIT = 3'd0,
    REG_VEL_X_LIMIT = 3'd1,
    REG_VEL_Y_LIMIT = 3'd2,
    REG_VEL_Z_LIMIT = 3'd3,
    REG_ALT_LIMIT   = 3'd4,
    REG_COUNT_LIMIT = 3'd5,
    REG_PERSIST_MS  = 3'd6,
    REG_BASE_ALT    = 3'd7
  } reg_idx_t;

  localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RST = 17'd100;
  localparam logic [LIMIT_W-1:0] VEL_LIMIT_RST   = 17'd100;
  localparam logic [LIMIT_W-1:0] ALT_LIMIT_RST   = 17'd200;
  localparam logic [CNT_W-1:0]   COUNT_LIMIT_RST = 3'd3;
  localparam logic [TIME_W-1:0]  PERSIST_MS_RST  = 32'd1000;
  localparam logic signed [VAL_W-1:0] BASE_ALT_RST = 16'sd0;

  typedef struct packed {
    logic [LIMIT_W-1:0]       speed_limit;
    logic [LIMIT_W-1:0]       vel_x_limit;
    logic [LIMIT_W-1:0]       vel_y_limit;
    logic [LIMIT_W-1:0]       vel_z_limit;
    logic [LIMIT_W-1:0]       alt_limit;
    logic [CNT_W-1:0]         count_limit;
    logic [TIME_W-1:0]        persist_ms;
    logic signed [VAL_W-1:0]  base_altitude;
  } cfg_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] rx_speed;
    logic signed [VAL_W-1:0] rx_vel_x;
    logic signed [VAL_W-1:0] rx_vel_y;
    logic signed [VAL_W-1:0] rx_vel_z;
    logic signed [VAL_W-1:0] rx_alt;
    logic signed [VAL_W-1:0] est_speed;
    logic signed [VAL_W-1:0] est_vel_x;
    logic signed [VAL_W-1:0] est_vel_y;
    logic signed [VAL_W-1:0] est_vel_z;
    logic signed [VAL_W-1:0] est_alt;
    logic [TIME_W-1:0]       now_ms;
  } sample_t;

  typedef struct packed {
    logic [CNT_W-1:0] exceed_count;
    logic             rx_zero;
  } cmp_t;

endpackage

### src/gsd_cfg_regs.sv
// Configuration register file with an APB-style access port.
module gsd_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [gsd_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [gsd_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [gsd_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready,
  output gsd_pkg::cfg_t                    cfg
);

  gsd_pkg::cfg_t      cfg_r;
  gsd_pkg::reg_idx_t  idx;
  logic               wr_en;

  assign idx        = gsd_pkg::reg_idx_t'(cfg_paddr[gsd_pkg::CFG_ADDR_W-1:2]);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_limit   <= gsd_pkg::SPEED_LIMIT_RST;
      cfg_r.vel_x_limit   <= gsd_pkg::VEL_LIMIT_RST;
      cfg_r.vel_y_limit   <= gsd_pkg::VEL_LIMIT_RST;
      cfg_r.vel_z_limit   <= gsd_pkg::VEL_LIMIT_RST;
      cfg_r.alt_limit     <= gsd_pkg::ALT_LIMIT_RST;
      cfg_r.count_limit   <= gsd_pkg::COUNT_LIMIT_RST;
      cfg_r.persist_ms    <= gsd_pkg::PERSIST_MS_RST;
      cfg_r.base_altitude <= gsd_pkg::BASE_ALT_RST;
    end else if (wr_en) begin
      case (idx)
        gsd_pkg::REG_SPEED_LIMIT: cfg_r.speed_limit <= cfg_pwdata[gsd_pkg::LIMIT_W-1:0];
        gsd_pkg::REG_VEL_X_LIMIT: cfg_r.vel_x_limit <= cfg_pwdata[gsd_pkg::LIMIT_W-1:0];
        gsd_pkg::REG_VEL_Y_LIMIT: cfg_r.vel_y_limit <= cfg_pwdata[gsd_pkg::LIMIT_W-1:0];
        gsd_pkg::REG_VEL_Z_LIMIT: cfg_r.vel_z_limit <= cfg_pwdata[gsd_pkg::LIMIT_W-1:0];
        gsd_pkg::REG_ALT_LIMIT:   cfg_r.alt_limit   <= cfg_pwdata[gsd_pkg::LIMIT_W-1:0];
        gsd_pkg::REG_COUNT_LIMIT: cfg_r.count_limit <= cfg_pwdata[gsd_pkg::CNT_W-1:0];
        gsd_pkg::REG_PERSIST_MS:  cfg_r.persist_ms  <= cfg_pwdata[gsd_pkg::TIME_W-1:0];
        gsd_pkg::REG_BASE_ALT:    cfg_r.base_altitude <= cfg_pwdata[gsd_pkg::VAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      gsd_pkg::REG_SPEED_LIMIT: cfg_prdata = {15'd0, cfg_r.speed_limit};
      gsd_pkg::REG_VEL_X_LIMIT: cfg_prdata = {15'd0, cfg_r.vel_x_limit};
      gsd_pkg::REG_VEL_Y_LIMIT: cfg_prdata = {15'd0, cfg_r.vel_y_limit};
      gsd_pkg::REG_VEL_Z_LIMIT: cfg_prdata = {15'd0, cfg_r.vel_z_limit};
      gsd_pkg::REG_ALT_LIMIT:   cfg_prdata = {15'd0, cfg_r.alt_limit};
      gsd_pkg::REG_COUNT_LIMIT: cfg_prdata = {29'd0, cfg_r.count_limit};
      gsd_pkg::REG_PERSIST_MS:  cfg_prdata = cfg_r.persist_ms;
      gsd_pkg::REG_BASE_ALT:    cfg_prdata = {{16{cfg_r.base_altitude[15]}},
                                              cfg_r.base_altitude};
      default:                  cfg_prdata = '0;
    endcase
  end

endmodule

### src/gsd_compare.sv
// Absolute differences against their limits and the exceed count.
module gsd_compare (
  input  gsd_pkg::sample_t sample,
  input  gsd_pkg::cfg_t    cfg,
  output gsd_pkg::cmp_t    cmp
);

  logic signed [16:0] d_speed, d_x, d_y, d_z;
  logic signed [17:0] d_alt;
  logic [gsd_pkg::LIMIT_W-1:0] a_speed, a_x, a_y, a_z, a_alt;
  logic [gsd_pkg::NUM_DIFFS-1:0] hit;

  always_comb begin
    d_speed = 17'(sample.rx_speed) - 17'(sample.est_speed);
    d_x     = 17'(sample.rx_vel_x) - 17'(sample.est_vel_x);
    d_y     = 17'(sample.rx_vel_y) - 17'(sample.est_vel_y);
    d_z     = 17'(sample.rx_vel_z) - 17'(sample.est_vel_z);
    d_alt   = 18'(sample.rx_alt) - 18'(cfg.base_altitude) - 18'(sample.est_alt);

    // Magnitudes fit 17 bits: at most 65535 for velocities, 98303 for altitude.
    a_speed = d_speed[16] ? 17'(-d_speed) : 17'(d_speed);
    a_x     = d_x[16]     ? 17'(-d_x)     : 17'(d_x);
    a_y     = d_y[16]     ? 17'(-d_y)     : 17'(d_y);
    a_z     = d_z[16]     ? 17'(-d_z)     : 17'(d_z);
    a_alt   = d_alt[17]   ? 17'(-d_alt)   : 17'(d_alt);

    hit[0] = a_speed >= cfg.speed_limit;
    hit[1] = a_x     >= cfg.vel_x_limit;
    hit[2] = a_y     >= cfg.vel_y_limit;
    hit[3] = a_z     >= cfg.vel_z_limit;
    hit[4] = a_alt   >= cfg.alt_limit;

    cmp.exceed_count = 3'(hit[0]) + 3'(hit[1]) + 3'(hit[2]) + 3'(hit[3]) + 3'(hit[4]);
    cmp.rx_zero      = (sample.rx_speed == '0) && (sample.rx_vel_x == '0) &&
                       (sample.rx_vel_y == '0) && (sample.rx_vel_z == '0) &&
                       (sample.rx_alt == '0);
  end

endmodule

### src/gnss_spoof_detector.sv
// Top level of the GNSS spoofing detector: input stage, decision and result register.
//
// Use: receiver and estimator samples enter on the in_ stream channel, one per
// item, each with the current millisecond time. Every accepted item yields exactly
// one result item on the out_ channel, in order: the spoofing flag, the number of
// differences that reached their limits and the unsafe flag.
// Thresholds, persistence time and base altitude are set through the cfg_ APB
// port; write them only while no item is in flight.
// Path: an accepted item is held in the input register, and its result then
// in the result register until out_tready takes it.
// Throughput: one item per cycle while the receiver is ready; the compare,
// count and wrapping time subtract for an item all settle between the two
// registers, and the last safe time register is the only state fed back.
// Reset: both stages empty, registers at their documented defaults, last safe
// time zero. When the receiver stalls, the result holds in the result register,
// the input register still takes one more item, and in_tready falls only once
// both stages are full.
module gnss_spoof_detector #(
  parameter logic REQUIRE_RX_DATA = gsd_pkg::REQUIRE_RX_DATA
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Fields from bit 0 up: rx_speed, rx_vel_x, rx_vel_y, rx_vel_z, rx_alt,
  // est_speed, est_vel_x, est_vel_y, est_vel_z, est_alt (16 each), now_ms (32).
  input  logic [gsd_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // Fields from bit 0 up: spoofed (1), exceed_count (3), sample_unsafe (1), zero pad.
  output logic [gsd_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [gsd_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [gsd_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [gsd_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  gsd_pkg::cfg_t    cfg;
  gsd_pkg::sample_t s1_r, s1_nxt;
  gsd_pkg::cmp_t    cmp;
  logic             s1_valid_r, s1_valid_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [gsd_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [gsd_pkg::TIME_W-1:0]     last_safe_r, last_safe_nxt;
  logic [gsd_pkg::TIME_W-1:0]     elapsed;
  logic             s2_ready, s1_fire, in_fire, unsafe, spoof;

  gsd_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  gsd_compare u_cmp (
    .sample (s1_r),
    .cfg    (cfg),
    .cmp    (cmp)
  );

  assign s2_ready  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && s2_ready;
  assign in_tready = !s1_valid_r || s2_ready;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_nxt.rx_speed  = in_tdata[15:0];
    s1_nxt.rx_vel_x  = in_tdata[31:16];
    s1_nxt.rx_vel_y  = in_tdata[47:32];
    s1_nxt.rx_vel_z  = in_tdata[63:48];
    s1_nxt.rx_alt    = in_tdata[79:64];
    s1_nxt.est_speed = in_tdata[95:80];
    s1_nxt.est_vel_x = in_tdata[111:96];
    s1_nxt.est_vel_y = in_tdata[127:112];
    s1_nxt.est_vel_z = in_tdata[143:128];
    s1_nxt.est_alt   = in_tdata[159:144];
    s1_nxt.now_ms    = in_tdata[191:160];

    s1_valid_nxt  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_fire ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

    // A safe sample refreshes the last safe time as its result is registered; its own elapsed time is zero.
    unsafe        = cmp.exceed_count >= cfg.count_limit;
    last_safe_nxt = (s1_fire && !unsafe) ? s1_r.now_ms : last_safe_r;
    elapsed       = s1_r.now_ms - (unsafe ? last_safe_r : s1_r.now_ms);
    spoof         = (elapsed >= cfg.persist_ms) &&
                    !(REQUIRE_RX_DATA && cmp.rx_zero);
    out_data_nxt  = {3'd0, unsafe, cmp.exceed_count, spoof};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      last_safe_r <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      last_safe_r <= last_safe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
    if (s1_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_last_safe_update: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && !unsafe |=> last_safe_r == $past(s1_r.now_ms))
    else $error("last safe time not taken from a safe item");

  a_safe_not_spoofed: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && !unsafe && (cfg.persist_ms != '0) |=> !out_tdata[0])
    else $error("safe item reported spoofing");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3:1] <= 3'(gsd_pkg::NUM_DIFFS))
    else $error("exceed count out of range");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input stalled with an empty input stage");

endmodule
